### design/quaternion_to_rotation_matrix_macros.svh
// Assertion macros for the quaternion to rotation matrix block.
// Used by the checker module; needs clk and arst_n in scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Check an implication on every clock edge outside reset
`define Q2R_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a signed 16-bit entry lies within plus or minus one in Q2.14
`define Q2R_UNIT_RANGE(label, cond, ent) \
	`Q2R_ASSERT(label, cond |-> ($signed(ent) <= 16'sd16384 && $signed(ent) >= -16'sd16384), \
		"entry out of unit range")

`endif

### design/q2r_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies.
package q2r_pkg;

	localparam int unsigned IN_W   = 16;   // input component width
	localparam int unsigned PROD_W = 32;   // product of two components
	localparam int unsigned NORM_W = 33;   // squared norm, up to 2^32
	localparam int unsigned NUM_W  = 49;   // signed scaled numerator
	localparam int unsigned REM_W  = 50;   // divider remainder
	localparam int unsigned QUO_W  = 16;   // quotient bits
	localparam int unsigned ENT_W  = 16;   // output entry width
	localparam int unsigned N_ENT  = 9;

	// Entry order, row-major
	localparam int unsigned E00 = 0;
	localparam int unsigned E01 = 1;
	localparam int unsigned E02 = 2;
	localparam int unsigned E10 = 3;
	localparam int unsigned E11 = 4;
	localparam int unsigned E12 = 5;
	localparam int unsigned E20 = 6;
	localparam int unsigned E21 = 7;
	localparam int unsigned E22 = 8;

	// Word between front and back
	typedef struct packed {
		logic                           zero;
		logic [NORM_W-1:0]              norm;
		logic [N_ENT-1:0][NUM_W-1:0]    num;
	} mid_word_t;

	// Word delivered to the result queue
	typedef struct packed {
		logic                           zero;
		logic [N_ENT-1:0][ENT_W-1:0]    ent;
	} out_word_t;

endpackage

### design/q2r_fifo.sv
// Small synchronous queue with flop storage.
// Depends on nothing; depth must be a power of two.
module q2r_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	// Store the word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### design/q2r_front.sv
// Front end: takes a quaternion, forms products, squared norm and numerators.
// Depends on q2r_pkg.
module q2r_front
	import q2r_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [IN_W-1:0]   quat_x,
	input  logic signed [IN_W-1:0]   quat_y,
	input  logic signed [IN_W-1:0]   quat_z,
	input  logic signed [IN_W-1:0]   quat_w,
	output logic                     mid_push,
	output mid_word_t                mid_word,
	input  logic                     mid_full
);
	logic adv;
	logic vld_s1, vld_s2;
	logic signed [PROD_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PROD_W-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	mid_word_t word_s2;
	mid_word_t word_d;
	logic [NORM_W-1:0] norm_d;

	// Stall the whole front when the last stage cannot drain
	assign adv      = !(vld_s2 && mid_full);
	assign full     = !adv;
	assign mid_push = vld_s2 && !mid_full;
	assign mid_word = word_s2;

	// Products of component pairs
	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			ww_s1 <= quat_w * quat_w;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
		end
	end

	// Diagonal numerator: 16384*N - 32768*(a + b)
	function automatic logic [NUM_W-1:0] diag_num(
		input logic [NORM_W-1:0]        n,
		input logic signed [PROD_W-1:0] a,
		input logic signed [PROD_W-1:0] b
	);
		logic signed [NUM_W-1:0] nn, ab;
		nn = $signed({2'b00, n, 14'd0});
		ab = $signed({{(NUM_W-PROD_W-16){a[PROD_W-1]}}, a, 15'd0})
		   + $signed({{(NUM_W-PROD_W-16){b[PROD_W-1]}}, b, 15'd0});
		return nn - ab;
	endfunction

	// Off-diagonal numerator: 32768*s, s of 33 bits
	function automatic logic [NUM_W-1:0] off_num(input logic signed [PROD_W:0] s);
		return {{(NUM_W-PROD_W-16){s[PROD_W]}}, s, 15'd0};
	endfunction

	// Squared norm and numerators
	always_comb begin
		norm_d = NORM_W'($unsigned(xx_s1)) + NORM_W'($unsigned(yy_s1))
		       + NORM_W'($unsigned(zz_s1)) + NORM_W'($unsigned(ww_s1));
		word_d.zero = (norm_d == '0);
		word_d.norm = norm_d;
		word_d.num[E00] = diag_num(norm_d, yy_s1, zz_s1);
		word_d.num[E11] = diag_num(norm_d, xx_s1, zz_s1);
		word_d.num[E22] = diag_num(norm_d, xx_s1, yy_s1);
		word_d.num[E01] = off_num((PROD_W+1)'(xy_s1) - (PROD_W+1)'(wz_s1));
		word_d.num[E02] = off_num((PROD_W+1)'(xz_s1) + (PROD_W+1)'(wy_s1));
		word_d.num[E10] = off_num((PROD_W+1)'(xy_s1) + (PROD_W+1)'(wz_s1));
		word_d.num[E12] = off_num((PROD_W+1)'(yz_s1) - (PROD_W+1)'(wx_s1));
		word_d.num[E20] = off_num((PROD_W+1)'(xz_s1) - (PROD_W+1)'(wy_s1));
		word_d.num[E21] = off_num((PROD_W+1)'(yz_s1) + (PROD_W+1)'(wx_s1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= word_d;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
		end
	end
endmodule

### design/q2r_back.sv
// Back end: nine pipelined restoring dividers, rounding and saturation.
// Depends on q2r_pkg.
module q2r_back
	import q2r_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_empty,
	input  mid_word_t mid_word,
	output logic      mid_pop,
	output logic      out_push,
	output out_word_t out_word,
	input  logic      out_full
);
	localparam int unsigned NS = QUO_W;

	logic                                adv;
	logic [NS:0]                         vld_s;
	logic [NS:0]                         zero_s;
	logic [NS:0][REM_W-1:0]              den_s;
	logic [NS:0][N_ENT-1:0][REM_W-1:0]   rem_s;
	logic [NS:0][N_ENT-1:0][QUO_W-1:0]   quo_s;
	logic [NS:0][N_ENT-1:0]              neg_s;

	assign adv      = !(vld_s[NS] && out_full);
	assign mid_pop  = adv && !mid_empty;
	assign out_push = adv && vld_s[NS];

	// Prepare: magnitude, rounded dividend 2|num| + N, divisor 2N
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= mid_word.zero;
			den_s[0]  <= REM_W'({mid_word.norm, 1'b0});
			for (int l = 0; l < N_ENT; l++) begin
				neg_s[0][l] <= mid_word.num[l][NUM_W-1];
				rem_s[0][l] <= REM_W'({(mid_word.num[l][NUM_W-1] ? -mid_word.num[l]
				                                                 : mid_word.num[l]), 1'b0})
				             + REM_W'(mid_word.norm);
				quo_s[0][l] <= '0;
			end
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int unsigned SH = NS - 1 - k;
		logic [REM_W-1:0] dsh;
		assign dsh = den_s[k] << SH;
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[k+1] <= zero_s[k];
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				for (int l = 0; l < N_ENT; l++) begin
					if (rem_s[k][l] >= dsh) begin
						rem_s[k+1][l] <= rem_s[k][l] - dsh;
						quo_s[k+1][l] <= quo_s[k][l] | (QUO_W'(1) << SH);
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						quo_s[k+1][l] <= quo_s[k][l];
					end
				end
			end
		end
	end

	// Apply sign, saturate, drop entries of a zero quaternion
	always_comb begin
		out_word.zero = zero_s[NS];
		for (int l = 0; l < N_ENT; l++) begin
			if (zero_s[NS]) begin
				out_word.ent[l] = '0;
			end else if (neg_s[NS][l]) begin
				out_word.ent[l] = (quo_s[NS][l] > 16'd32768) ? 16'h8000
				                                             : ENT_W'(-quo_s[NS][l]);
			end else begin
				out_word.ent[l] = (quo_s[NS][l] > 16'd32767) ? 16'h7fff : quo_s[NS][l];
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-1:0], mid_pop};
		end
	end
endmodule

### design/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, signed Q2.14 in and out.
// Depends on q2r_pkg, q2r_front, q2r_fifo, q2r_back.
// Input channel: a queue write port. A quaternion (quat_x..quat_w) is taken
// on a clock edge with push high and full low.
// Result channel: a queue read port. While empty is low the oldest result
// (row0_col0..row2_col2, zero_norm) is on the ports; pop takes it.
// One word in gives one word out, in order. Entries are scaled by 2/N with
// N the squared norm, rounded to nearest and saturated; an all-zero
// quaternion gives zero entries with zero_norm set.
// Throughput: one word per cycle while the receiver keeps popping, set by
// the nine dividers being pipelined one quotient bit per stage. Path from
// the accepting edge to empty going low: two front stages, the middle queue,
// one prepare stage, sixteen divider stages and the result queue.
// Reset clears all valid bits and queue pointers; no word survives it.
// When the receiver stops popping, the result queue fills, the divider
// pipeline holds, the middle queue fills, and then full rises.
module quaternion_to_rotation_matrix
	import q2r_pkg::*;
#(
	parameter int unsigned MID_DEPTH = 4,
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [IN_W-1:0]  quat_x,
	input  logic signed [IN_W-1:0]  quat_y,
	input  logic signed [IN_W-1:0]  quat_z,
	input  logic signed [IN_W-1:0]  quat_w,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [ENT_W-1:0] row0_col0,
	output logic signed [ENT_W-1:0] row0_col1,
	output logic signed [ENT_W-1:0] row0_col2,
	output logic signed [ENT_W-1:0] row1_col0,
	output logic signed [ENT_W-1:0] row1_col1,
	output logic signed [ENT_W-1:0] row1_col2,
	output logic signed [ENT_W-1:0] row2_col0,
	output logic signed [ENT_W-1:0] row2_col1,
	output logic signed [ENT_W-1:0] row2_col2,
	output logic                    zero_norm
);
	logic      mid_push, mid_full, mid_pop, mid_empty;
	mid_word_t mid_in, mid_out;
	logic      out_push, out_full;
	out_word_t out_in, out_out;

	q2r_front u_front (
		.clk, .arst_n, .push, .full,
		.quat_x, .quat_y, .quat_z, .quat_w,
		.mid_push, .mid_word(mid_in), .mid_full
	);

	q2r_fifo #(.W($bits(mid_word_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk, .arst_n,
		.push(mid_push), .din(mid_in), .full(mid_full),
		.pop(mid_pop), .dout(mid_out), .empty(mid_empty)
	);

	q2r_back u_back (
		.clk, .arst_n,
		.mid_empty, .mid_word(mid_out), .mid_pop,
		.out_push, .out_word(out_in), .out_full
	);

	q2r_fifo #(.W($bits(out_word_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk, .arst_n,
		.push(out_push), .din(out_in), .full(out_full),
		.pop, .dout(out_out), .empty
	);

	// Unpack the result word
	assign row0_col0 = out_out.ent[E00];
	assign row0_col1 = out_out.ent[E01];
	assign row0_col2 = out_out.ent[E02];
	assign row1_col0 = out_out.ent[E10];
	assign row1_col1 = out_out.ent[E11];
	assign row1_col2 = out_out.ent[E12];
	assign row2_col0 = out_out.ent[E20];
	assign row2_col1 = out_out.ent[E21];
	assign row2_col2 = out_out.ent[E22];
	assign zero_norm = out_out.zero;
endmodule

### design/q2r_checker.sv
// Port-level checks for the quaternion to rotation matrix block, with bind.
// Depends on q2r_pkg and quaternion_to_rotation_matrix_macros.svh.
`include "quaternion_to_rotation_matrix_macros.svh"
module q2r_checker
	import q2r_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [ENT_W-1:0] row0_col0,
	input logic [ENT_W-1:0] row1_col1,
	input logic [ENT_W-1:0] row2_col2,
	input logic [ENT_W-1:0] row0_col1,
	input logic             zero_norm
);
	// A zero quaternion yields zero diagonal entries and a zero row0_col1
	`Q2R_ASSERT(a_zero_entries, (!empty && zero_norm) |-> (row0_col0 == '0 && row1_col1 == '0 && row2_col2 == '0 && row0_col1 == '0), "zero quaternion with nonzero entries")

	// A waiting word stays until popped
	`Q2R_ASSERT(a_hold, (!empty && !pop) |=> !empty, "result dropped without pop")

	// Entries row0_col0 and row0_col1 stay within one in magnitude
	`Q2R_UNIT_RANGE(a_rng00, !empty, row0_col0)
	`Q2R_UNIT_RANGE(a_rng01, !empty, row0_col1)
endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (
	.clk, .arst_n, .empty, .pop,
	.row0_col0, .row1_col1, .row2_col2, .row0_col1, .zero_norm
);

### tb/sv/q2r_checker.sv
// Result checker for the quaternion to rotation matrix block.
// Watches both queue ports, predicts each matrix and compares; uses q2r_pkg.
module q2r_scoreboard
	import q2r_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic signed [IN_W-1:0]  quat_x,
	input  logic signed [IN_W-1:0]  quat_y,
	input  logic signed [IN_W-1:0]  quat_z,
	input  logic signed [IN_W-1:0]  quat_w,
	input  logic                    empty,
	input  logic                    pop,
	input  logic signed [ENT_W-1:0] row0_col0,
	input  logic signed [ENT_W-1:0] row0_col1,
	input  logic signed [ENT_W-1:0] row0_col2,
	input  logic signed [ENT_W-1:0] row1_col0,
	input  logic signed [ENT_W-1:0] row1_col1,
	input  logic signed [ENT_W-1:0] row1_col2,
	input  logic signed [ENT_W-1:0] row2_col0,
	input  logic signed [ENT_W-1:0] row2_col1,
	input  logic signed [ENT_W-1:0] row2_col2,
	input  logic                    zero_norm,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	out_word_t matrix_q[$];

	// Round num/den to nearest, ties away from zero, then clamp to 16 bits
	function automatic logic [ENT_W-1:0] scaled_entry(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (num < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[ENT_W-1:0];
	endfunction

	function automatic out_word_t rotation_of(longint x, longint y, longint z, longint w);
		out_word_t r;
		longint n;
		n = x * x + y * y + z * z + w * w;
		r = '0;
		if (n == 0) begin
			r.zero = 1'b1;
			return r;
		end
		r.ent[E00] = scaled_entry(n * 16384 - (y * y + z * z) * 32768, n);
		r.ent[E01] = scaled_entry((x * y - w * z) * 32768, n);
		r.ent[E02] = scaled_entry((x * z + w * y) * 32768, n);
		r.ent[E10] = scaled_entry((x * y + w * z) * 32768, n);
		r.ent[E11] = scaled_entry(n * 16384 - (x * x + z * z) * 32768, n);
		r.ent[E12] = scaled_entry((y * z - w * x) * 32768, n);
		r.ent[E20] = scaled_entry((x * z - w * y) * 32768, n);
		r.ent[E21] = scaled_entry((y * z + w * x) * 32768, n);
		r.ent[E22] = scaled_entry(n * 16384 - (x * x + y * y) * 32768, n);
		return r;
	endfunction

	assign pending = matrix_q.size();

	// Predict on each accepted word, compare on each popped word
	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n) begin
			if (push && !full)
				matrix_q.push_back(rotation_of(quat_x, quat_y, quat_z, quat_w));
			if (pop && !empty) begin
				got.zero = zero_norm;
				got.ent = {row2_col2, row2_col1, row2_col0, row1_col2, row1_col1,
					row1_col0, row0_col2, row0_col1, row0_col0};
				if (matrix_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: %h", got);
				end else begin
					want = matrix_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h got %h", want, got);
					end
				end
			end
		end
	end

	initial errors = 0;
endmodule

### tb/sv/tb.sv
// Top of the quaternion to rotation matrix testbench.
// Drives quaternions and pops results; depends on q2r_pkg and q2r_scoreboard.
module tb;
	import q2r_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, zero_norm;
	logic signed [IN_W-1:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic signed [ENT_W-1:0] row0_col0, row0_col1, row0_col2, row1_col0, row1_col1;
	logic signed [ENT_W-1:0] row1_col2, row2_col0, row2_col1, row2_col2;
	int errors, pending;
	bit sending = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quaternion_to_rotation_matrix dut (.*);
	q2r_scoreboard chk (.*);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// Random component: full range, extremes, or small values
	function automatic logic [IN_W-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold one word on the port until accepted; push stays high back to back
	task automatic send_word(logic [IN_W-1:0] x, y, z, w);
		int g;
		g = gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		quat_w <= w;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pop with random stalls; stretches with no stall at all
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0 && sending)
				g = gap_len();
			else
				g = 0;
			pop <= (g == 0);
			if (g > 0) begin
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Directed: zero, identity, extremes, single axes, unnormalized
		send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'h0000, 16'h0000, 16'h0000, 16'h4000);
		send_word(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		send_word(16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_word(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_word(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'hffff, 16'h0001, 16'hffff, 16'h0001);
		send_word(16'h2000, 16'h2000, 16'h2000, 16'h2000);
		send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'h0003, 16'hfffd, 16'h0001, 16'h0002);
		send_word(16'h5555, 16'haaaa, 16'h0000, 16'h0000);
		for (int i = 0; i < 1400; i++)
			send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		push <= 1'b0;
		sending = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

### sim.f
+incdir+design
design/q2r_pkg.sv
design/q2r_fifo.sv
design/q2r_front.sv
design/q2r_back.sv
design/quaternion_to_rotation_matrix.sv
design/q2r_checker.sv
tb/sv/q2r_checker.sv
tb/sv/tb.sv
